@@ rtl/rwlm_pkg.sv @@
// ----------------------------------------------------------------------------
// rwlm_pkg
// Shared types and codes for the reader/writer lock manager: request and
// result words, decoded command, action and outcome codes, back-end state.
// ----------------------------------------------------------------------------
`default_nettype none

package rwlm_pkg;

    // thread identifier width, fixed by the word layout
    localparam int TID_W = 8;

    // request action codes
    localparam logic [2:0] ACT_EX_LOCK   = 3'd0;
    localparam logic [2:0] ACT_EX_TRY    = 3'd1;
    localparam logic [2:0] ACT_SH_LOCK   = 3'd2;
    localparam logic [2:0] ACT_SH_TRY    = 3'd3;
    localparam logic [2:0] ACT_UPGRADE   = 3'd4;
    localparam logic [2:0] ACT_EX_UNLOCK = 3'd5;
    localparam logic [2:0] ACT_SH_UNLOCK = 3'd6;

    // result outcome codes
    localparam logic [2:0] OC_GRANTED    = 3'd0;
    localparam logic [2:0] OC_REFUSED    = 3'd1;
    localparam logic [2:0] OC_QUEUED     = 3'd2;
    localparam logic [2:0] OC_WOKEN      = 3'd3;
    localparam logic [2:0] OC_RELEASED   = 3'd4;
    localparam logic [2:0] OC_NOT_HOLDER = 3'd5;
    localparam logic [2:0] OC_FULL       = 3'd6;

    // most readers one exclusive unlock may wake
    localparam int WAKE_LIMIT = 16;

    typedef struct packed {
        logic [2:0]       action;
        logic [TID_W-1:0] thread_id;
    } t_in_word;

    typedef struct packed {
        logic [2:0]       outcome;
        logic [TID_W-1:0] thread_out;
        logic [7:0]       readers_after;
        logic             exclusive_after;
        logic             last;
    } t_out_word;

    // decoded operation class
    typedef enum logic [2:0] {
        OP_EX_LOCK,
        OP_SH_LOCK,
        OP_UPGRADE,
        OP_EX_UNLOCK,
        OP_SH_UNLOCK,
        OP_BAD
    } t_op;

    typedef struct packed {
        t_op              op;
        logic             try_only;
        logic [TID_W-1:0] tid;
    } t_cmd;

    typedef enum logic [1:0] {
        BK_FETCH,
        BK_EXEC,
        BK_WAKE
    } t_bk_state;

    // back-end status seen by the top-level checks
    typedef struct packed {
        logic excl;
        logic rd_zero;
        logic wq_empty;
        logic wq_over;
        logic rq_over;
        logic waking;
    } t_bk_status;

endpackage

`default_nettype wire

@@ rtl/rwlm_front.sv @@
// ----------------------------------------------------------------------------
// rwlm_front
// Request intake: decodes each request word into an operation class and
// parks it in a two-entry command queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rwlm_front (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    output logic                    o_in_stall,
    input  wire rwlm_pkg::t_in_word i_in_word,
    output logic                    o_cmd_valid,
    input  wire                     i_cmd_pop,
    output rwlm_pkg::t_cmd          o_cmd
);
    import rwlm_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;
    t_cmd       dec_cmd;
    logic       push;
    logic       pop;

    // action decode
    always_comb begin
        dec_cmd.tid      = i_in_word.thread_id;
        dec_cmd.try_only = 1'b0;
        unique case (i_in_word.action)
            ACT_EX_LOCK:   dec_cmd.op = OP_EX_LOCK;
            ACT_EX_TRY: begin
                dec_cmd.op       = OP_EX_LOCK;
                dec_cmd.try_only = 1'b1;
            end
            ACT_SH_LOCK:   dec_cmd.op = OP_SH_LOCK;
            ACT_SH_TRY: begin
                dec_cmd.op       = OP_SH_LOCK;
                dec_cmd.try_only = 1'b1;
            end
            ACT_UPGRADE:   dec_cmd.op = OP_UPGRADE;
            ACT_EX_UNLOCK: dec_cmd.op = OP_EX_UNLOCK;
            ACT_SH_UNLOCK: dec_cmd.op = OP_SH_UNLOCK;
            default:       dec_cmd.op = OP_BAD;
        endcase
    end

    // two-entry command queue
    assign o_in_stall  = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_slot[r_rd_ptr];
    assign push        = i_in_valid && !o_in_stall;
    assign pop         = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= dec_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/rwlm_back.sv @@
// ----------------------------------------------------------------------------
// rwlm_back
// Lock engine: holder state, writer and reader wait queues, result register.
// Fetches one command, executes it, and drains woken readers one a cycle while the output is not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module rwlm_back #(
    parameter int WAIT_DEPTH = 16,
    parameter int READER_MAX = 255
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cmd_valid,
    input  wire rwlm_pkg::t_cmd  i_cmd,
    output logic                 o_cmd_pop,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output rwlm_pkg::t_out_word  o_out_word,
    output rwlm_pkg::t_bk_status o_status
);
    import rwlm_pkg::*;

    localparam int AW       = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int CW       = $clog2(WAIT_DEPTH + 1);
    localparam int RW       = (READER_MAX > 1) ? $clog2(READER_MAX + 1) : 1;
    localparam int WAKE_CAP = (READER_MAX < WAKE_LIMIT) ? READER_MAX : WAKE_LIMIT;

    // wait queue storage
    logic [TID_W-1:0] wq_mem [WAIT_DEPTH];
    logic [TID_W-1:0] rq_mem [WAIT_DEPTH];

    t_bk_state        r_state, n_state;
    t_cmd             r_cmd;
    logic [RW-1:0]    r_rt, n_rt;
    logic             r_ex, n_ex;
    logic [TID_W-1:0] r_owner, n_owner;
    logic [AW-1:0]    r_wq_head, n_wq_head, r_wq_tail;
    logic [AW-1:0]    r_rq_head, n_rq_head, r_rq_tail;
    logic [CW-1:0]    r_wq_cnt, r_rq_cnt;
    logic [TID_W-1:0] r_wq_data, r_rq_data;
    logic [4:0]       r_wake_left, n_wake_left;
    logic             r_out_valid;
    t_out_word        r_out;

    logic             out_free;
    logic             emit;
    logic [2:0]       res_code;
    logic [TID_W-1:0] res_tid;
    logic             res_last;
    logic             exec_wake;
    logic             wq_push, wq_pop, rq_push, rq_pop;
    logic             wq_full, rq_full;
    logic             free_ex, free_sh;
    logic [4:0]       wake_n;
    logic [RW+7:0]    rt_ext;

    assign out_free = !r_out_valid || !i_out_stall;
    assign wq_full  = (r_wq_cnt == CW'(WAIT_DEPTH));
    assign rq_full  = (r_rq_cnt == CW'(WAIT_DEPTH));
    assign free_ex  = !r_ex && (r_rt == '0) && (r_wq_cnt == '0);
    assign free_sh  = !r_ex && (r_wq_cnt == '0);
    assign wake_n   = (32'(r_rq_cnt) > 32'(WAKE_CAP)) ? 5'(WAKE_CAP) : 5'(r_rq_cnt);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_FETCH: begin
                if (i_cmd_valid) begin
                    n_state = BK_EXEC;
                end
            end
            BK_EXEC: begin
                if (out_free) begin
                    n_state = exec_wake ? BK_WAKE : BK_FETCH;
                end
            end
            BK_WAKE: begin
                if (out_free && (r_wake_left == 5'd1)) begin
                    n_state = BK_FETCH;
                end
            end
            default: n_state = BK_FETCH;
        endcase
    end

    // state machine outputs
    always_comb begin
        o_cmd_pop = (r_state == BK_FETCH) && i_cmd_valid;
    end

    // command execution
    always_comb begin
        n_rt        = r_rt;
        n_ex        = r_ex;
        n_owner     = r_owner;
        n_wake_left = r_wake_left;
        wq_push     = 1'b0;
        wq_pop      = 1'b0;
        rq_push     = 1'b0;
        rq_pop      = 1'b0;
        emit        = 1'b0;
        exec_wake   = 1'b0;
        res_code    = OC_REFUSED;
        res_tid     = r_cmd.tid;
        res_last    = 1'b1;

        if ((r_state == BK_EXEC) && out_free) begin
            emit = 1'b1;
            case (r_cmd.op)
                OP_EX_LOCK: begin
                    if (free_ex) begin
                        n_ex     = 1'b1;
                        n_owner  = r_cmd.tid;
                        res_code = OC_GRANTED;
                    end else if (r_cmd.try_only) begin
                        res_code = OC_REFUSED;
                    end else if (wq_full) begin
                        res_code = OC_FULL;
                    end else begin
                        wq_push  = 1'b1;
                        res_code = OC_QUEUED;
                    end
                end
                OP_SH_LOCK: begin
                    if (free_sh) begin
                        if (32'(r_rt) >= READER_MAX) begin
                            res_code = OC_FULL;
                        end else begin
                            n_rt     = r_rt + RW'(1);
                            res_code = OC_GRANTED;
                        end
                    end else if (r_cmd.try_only) begin
                        res_code = OC_REFUSED;
                    end else if (rq_full) begin
                        res_code = OC_FULL;
                    end else begin
                        rq_push  = 1'b1;
                        res_code = OC_QUEUED;
                    end
                end
                OP_UPGRADE: begin
                    if (r_ex || (r_rt == '0)) begin
                        res_code = OC_NOT_HOLDER;
                    end else if (r_rt == RW'(1)) begin
                        n_rt     = '0;
                        n_ex     = 1'b1;
                        n_owner  = r_cmd.tid;
                        res_code = OC_GRANTED;
                    end else if (wq_full) begin
                        res_code = OC_FULL;
                    end else begin
                        // drop own read hold, then wait as a writer
                        n_rt     = r_rt - RW'(1);
                        wq_push  = 1'b1;
                        res_code = OC_QUEUED;
                    end
                end
                OP_EX_UNLOCK: begin
                    if (!r_ex || (r_owner != r_cmd.tid)) begin
                        res_code = OC_NOT_HOLDER;
                    end else if (r_wq_cnt != '0) begin
                        // hand off to the oldest writer
                        wq_pop   = 1'b1;
                        n_owner  = r_wq_data;
                        res_code = OC_WOKEN;
                        res_tid  = r_wq_data;
                    end else begin
                        n_ex    = 1'b0;
                        n_owner = '0;
                        if (r_rq_cnt == '0) begin
                            n_rt     = '0;
                            res_code = OC_RELEASED;
                        end else begin
                            // readers are woken afterwards, in the wake state
                            n_rt        = RW'(wake_n);
                            n_wake_left = wake_n;
                            exec_wake   = 1'b1;
                            emit        = 1'b0;
                        end
                    end
                end
                OP_SH_UNLOCK: begin
                    if (r_ex || (r_rt == '0)) begin
                        res_code = OC_NOT_HOLDER;
                    end else begin
                        n_rt = r_rt - RW'(1);
                        if ((r_rt == RW'(1)) && (r_wq_cnt != '0)) begin
                            wq_pop   = 1'b1;
                            n_ex     = 1'b1;
                            n_owner  = r_wq_data;
                            res_code = OC_WOKEN;
                            res_tid  = r_wq_data;
                        end else begin
                            res_code = OC_RELEASED;
                        end
                    end
                end
                default: res_code = OC_REFUSED;
            endcase
        end else if ((r_state == BK_WAKE) && out_free) begin
            emit        = 1'b1;
            rq_pop      = 1'b1;
            res_code    = OC_WOKEN;
            res_tid     = r_rq_data;
            res_last    = (r_wake_left == 5'd1);
            n_wake_left = r_wake_left - 5'd1;
        end
    end

    // next head pointers; reads look one step ahead
    always_comb begin
        n_wq_head = r_wq_head;
        n_rq_head = r_rq_head;
        if (wq_pop) begin
            n_wq_head = (r_wq_head == AW'(WAIT_DEPTH - 1)) ? '0 : r_wq_head + AW'(1);
        end
        if (rq_pop) begin
            n_rq_head = (r_rq_head == AW'(WAIT_DEPTH - 1)) ? '0 : r_rq_head + AW'(1);
        end
    end

    // queue memories with registered head read
    always_ff @(posedge i_clk) begin
        if (wq_push) begin
            wq_mem[r_wq_tail] <= r_cmd.tid;
        end
        if (rq_push) begin
            rq_mem[r_rq_tail] <= r_cmd.tid;
        end
        r_wq_data <= wq_mem[n_wq_head];
        r_rq_data <= rq_mem[n_rq_head];
    end

    // command capture and result payload
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
        if (out_free && emit) begin
            r_out.outcome         <= res_code;
            r_out.thread_out      <= res_tid;
            r_out.readers_after   <= rt_ext[7:0];
            r_out.exclusive_after <= n_ex;
            r_out.last            <= res_last;
        end
    end

    assign rt_ext = {8'd0, n_rt};

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_FETCH;
            r_rt        <= '0;
            r_ex        <= 1'b0;
            r_owner     <= '0;
            r_wq_head   <= '0;
            r_wq_tail   <= '0;
            r_wq_cnt    <= '0;
            r_rq_head   <= '0;
            r_rq_tail   <= '0;
            r_rq_cnt    <= '0;
            r_wake_left <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rt        <= n_rt;
            r_ex        <= n_ex;
            r_owner     <= n_owner;
            r_wake_left <= n_wake_left;
            r_wq_head   <= n_wq_head;
            r_rq_head   <= n_rq_head;
            if (wq_push) begin
                r_wq_tail <= (r_wq_tail == AW'(WAIT_DEPTH - 1)) ? '0 : r_wq_tail + AW'(1);
                r_wq_cnt  <= r_wq_cnt + CW'(1);
            end else if (wq_pop) begin
                r_wq_cnt  <= r_wq_cnt - CW'(1);
            end
            if (rq_push) begin
                r_rq_tail <= (r_rq_tail == AW'(WAIT_DEPTH - 1)) ? '0 : r_rq_tail + AW'(1);
                r_rq_cnt  <= r_rq_cnt + CW'(1);
            end else if (rq_pop) begin
                r_rq_cnt  <= r_rq_cnt - CW'(1);
            end
            if (out_free) begin
                r_out_valid <= emit;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    assign o_status.excl     = r_ex;
    assign o_status.rd_zero  = (r_rt == '0);
    assign o_status.wq_empty = (r_wq_cnt == '0);
    assign o_status.wq_over  = (32'(r_wq_cnt) > WAIT_DEPTH);
    assign o_status.rq_over  = (32'(r_rq_cnt) > WAIT_DEPTH);
    assign o_status.waking   = (r_state == BK_WAKE);

endmodule

`default_nettype wire

@@ rtl/rw_lock_manager.sv @@
// ----------------------------------------------------------------------------
// rw_lock_manager
// Writer-preferring reader/writer lock manager with FIFO wait queues for
// writers and readers; a front end decodes requests, a back end runs them.
//
//   channel  direction  valid        stall        word
//   request  in         i_in_valid   o_in_stall   i_in_word  (t_in_word)
//   result   out        o_out_valid  i_out_stall  o_out_word (t_out_word)
//
// The back end fetches a request as a command, then executes it. An
// exclusive unlock waking readers adds one reader-queue read per cycle,
// unless stalled. The front queue holds two requests, so input is taken
// while the back end works or a result waits in the output register.
// Reset is synchronous; wait queue storage needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module rw_lock_manager #(
    parameter int WAIT_DEPTH = 16,
    parameter int READER_MAX = 255
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    output logic                    o_in_stall,
    input  wire rwlm_pkg::t_in_word i_in_word,
    output logic                    o_out_valid,
    input  wire                     i_out_stall,
    output rwlm_pkg::t_out_word     o_out_word
);
    import rwlm_pkg::*;

    logic       cmd_valid;
    logic       cmd_pop;
    t_cmd       cmd;
    t_bk_status status;

    rwlm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop),
        .o_cmd       (cmd)
    );

    rwlm_back #(
        .WAIT_DEPTH (WAIT_DEPTH),
        .READER_MAX (READER_MAX)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .o_status    (status)
    );

    // an exclusive owner never coexists with read holds
    a_excl_no_readers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.excl |-> status.rd_zero)
        else $error("exclusive owner with nonzero reader count");

    // wait queue occupancy stays within depth
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !status.wq_over && !status.rq_over)
        else $error("wait queue count beyond depth");

    // readers are only woken when no writer waits
    a_wake_writer_pref: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.waking |-> (status.wq_empty && !status.excl))
        else $error("reader wake while a writer waits or owns the lock");

    // reported state agrees on exclusive ownership
    a_out_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.exclusive_after) |-> (o_out_word.readers_after == 8'd0))
        else $error("result reports readers under exclusive hold");

endmodule

`default_nettype wire
